FILE: rtl/core/ordered_multimap_table_macros.svh
// Assertion macros used by the ordered multimap table RTL.
`ifndef ORDERED_MULTIMAP_TABLE_MACROS_SVH
`define ORDERED_MULTIMAP_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// Check that cond holds in the same cycle as trig.
`define OTM_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("otm assertion failed");

// Check that cond holds in the cycle after trig.
`define OTM_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("otm assertion failed");

`else

`define OTM_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define OTM_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

FILE: rtl/core/otm_pkg.sv
// Types, codes and default sizes of the ordered multimap table.
package otm_pkg;

    // Fixed port field widths
    localparam int CMD_W      = 2;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 64;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 5;

    // Default table geometry
    localparam int DEPTH_DEF      = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

endpackage

FILE: rtl/core/otm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module otm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ordered_multimap_table.sv
// Ordered multimap table: key/value pairs in insertion order, duplicates allowed.
// Add and unused commands: one result word in the cycle after start; busy stays low.
// Remove and find: walk the n held pairs, one RAM read per cycle; busy stays high for the walk,
// the last word shows as busy falls, earlier find words one match late.
// Results cannot be stalled; each word is shown for one cycle under o_strobe.
// Synchronous active-low reset empties the table at once; RAM contents are not cleared.
`include "ordered_multimap_table_macros.svh"

module ordered_multimap_table #(
    parameter int DEPTH      = otm_pkg::DEPTH_DEF,
    parameter int KEY_BITS   = otm_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = otm_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [otm_pkg::CMD_W-1:0]       i_cmd,
    input  logic [otm_pkg::KEY_W-1:0]       i_key,
    input  logic [otm_pkg::VALUE_W-1:0]     i_value,
    output logic                            o_strobe,
    output logic [otm_pkg::STATUS_W-1:0]    o_status,
    output logic [otm_pkg::VALUE_W-1:0]     o_found_value,
    output logic                            o_value_valid,
    output logic [otm_pkg::CNT_OUT_W-1:0]   o_removed_count,
    output logic [otm_pkg::CNT_OUT_W-1:0]   o_entries_held,
    output logic                            o_last
);

    import otm_pkg::*;

    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = KEY_BITS + VALUE_BITS;

    // Sequencer state
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_fill, n_fill;      // pairs held
    logic [CNT_W-1:0]      r_idx, n_idx;        // next entry to read
    logic [CNT_W-1:0]      r_wj, n_wj;          // next compaction slot
    logic                  r_dvld, n_dvld;      // read data arrives this cycle
    logic                  r_is_find, n_is_find;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic                  r_have_pend, n_have_pend;
    logic [VALUE_BITS-1:0] r_pend, n_pend;      // match held back until last is known

    // Result word registers
    logic                  r_strobe, n_strobe;
    t_status               r_status, n_status;
    logic [VALUE_BITS-1:0] r_fv, n_fv;
    logic                  r_vv, n_vv;
    logic [CNT_W-1:0]      r_removed, n_removed;
    logic                  r_last, n_last;

    // RAM port signals
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;

    logic accept;
    logic full;
    logic scan_issue;
    logic scan_end;
    logic hit;
    logic keep;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && (r_state == ST_IDLE);
    assign full   = (r_fill == CNT_W'(DEPTH));

    assign rd_key = ram_rdata[ENTRY_W-1:VALUE_BITS];
    assign rd_val = ram_rdata[VALUE_BITS-1:0];

    // Walk: issue one read per cycle, consume the data in the cycle after.
    assign scan_issue = (r_state == ST_SCAN) && (r_idx < r_fill);
    assign scan_end   = (r_state == ST_SCAN) && (r_idx == r_fill) && !r_dvld;
    assign hit        = r_dvld && (rd_key == r_key);
    // Survivors of a remove slide down to the compaction slot, which never passes
    // the read index, so a write never lands on an entry still to be read.
    assign keep       = r_dvld && !r_is_find && !hit;

    assign ram_re    = scan_issue;
    assign ram_we    = (accept && (t_cmd'(i_cmd) == CMD_ADD) && !full) || keep;
    assign ram_waddr = (r_state == ST_IDLE) ? r_fill[ADDR_W-1:0] : r_wj[ADDR_W-1:0];
    assign ram_wdata = (r_state == ST_IDLE)
                     ? {i_key[KEY_BITS-1:0], i_value[VALUE_BITS-1:0]}
                     : ram_rdata;

    otm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_wj        = r_wj;
        n_dvld      = scan_issue;
        n_is_find   = r_is_find;
        n_key       = r_key;
        n_have_pend = r_have_pend;
        n_pend      = r_pend;

        n_strobe    = 1'b0;
        n_status    = STATUS_OK;
        n_fv        = '0;
        n_vv        = 1'b0;
        n_removed   = '0;
        n_last      = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_ADD: begin
                            // Append at the tail, or drop and flag full.
                            n_strobe = 1'b1;
                            if (full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                n_fill = r_fill + CNT_W'(1);
                            end
                        end
                        CMD_REMOVE, CMD_FIND: begin
                            n_state     = ST_SCAN;
                            n_idx       = '0;
                            n_wj        = '0;
                            n_dvld      = 1'b0;
                            n_is_find   = (t_cmd'(i_cmd) == CMD_FIND);
                            n_key       = i_key[KEY_BITS-1:0];
                            n_have_pend = 1'b0;
                        end
                        default: begin
                            // Unused command: answer ok, change nothing.
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (keep) begin
                    n_wj = r_wj + CNT_W'(1);
                end
                if (r_is_find && hit) begin
                    // Release the previous match; hold this one back.
                    if (r_have_pend) begin
                        n_strobe = 1'b1;
                        n_fv     = r_pend;
                        n_vv     = 1'b1;
                        n_last   = 1'b0;
                    end
                    n_pend      = rd_val;
                    n_have_pend = 1'b1;
                end
                if (scan_end) begin
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                    if (r_is_find) begin
                        if (r_have_pend) begin
                            n_fv = r_pend;
                            n_vv = 1'b1;
                        end else begin
                            n_status = STATUS_NOTFOUND;
                        end
                    end else begin
                        n_removed = r_fill - r_wj;
                        n_fill    = r_wj;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_wj        <= '0;
            r_dvld      <= 1'b0;
            r_is_find   <= 1'b0;
            r_have_pend <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_wj        <= n_wj;
            r_dvld      <= n_dvld;
            r_is_find   <= n_is_find;
            r_have_pend <= n_have_pend;
            r_strobe    <= n_strobe;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_pend    <= n_pend;
        r_status  <= n_status;
        r_fv      <= n_fv;
        r_vv      <= n_vv;
        r_removed <= n_removed;
        r_last    <= n_last;
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_found_value   = VALUE_W'(r_fv);
    assign o_value_valid   = r_vv;
    assign o_removed_count = CNT_OUT_W'(r_removed);
    assign o_entries_held  = CNT_OUT_W'(r_fill);
    assign o_last          = r_last;

    `OTM_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(DEPTH))
    `OTM_ASSERT_SAME(a_compact_behind, i_clk, i_rst_n, r_state == ST_SCAN, r_wj <= r_idx)
    `OTM_ASSERT_NEXT(a_add_one_word, i_clk, i_rst_n,
        accept && (i_cmd != CMD_REMOVE) && (i_cmd != CMD_FIND), o_strobe && o_last)
    `OTM_ASSERT_SAME(a_idle_word_last, i_clk, i_rst_n,
        o_strobe && (r_state == ST_IDLE), o_last)

endmodule

FILE: tb/tb_ordered_multimap_table.sv
// Self-checking testbench for the ordered multimap table: add, remove and find words.
module tb_ordered_multimap_table;
    timeunit 1ns;
    timeprecision 1ps;

    import otm_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 300000;
    // The cmd field has one code that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [VALUE_W-1:0]   value;
        logic                 vld;
        logic [CNT_OUT_W-1:0] removed;
        logic [CNT_OUT_W-1:0] held;
        logic                 last;
    } result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     i_cmd = '0;
    logic [KEY_W-1:0]     i_key = '0;
    logic [VALUE_W-1:0]   i_value = '0;
    logic                 o_strobe;
    logic [STATUS_W-1:0]  o_status;
    logic [VALUE_W-1:0]   o_found_value;
    logic                 o_value_valid;
    logic [CNT_OUT_W-1:0] o_removed_count;
    logic [CNT_OUT_W-1:0] o_entries_held;
    logic                 o_last;

    ordered_multimap_table uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_found_value  (o_found_value),
        .o_value_valid  (o_value_valid),
        .o_removed_count(o_removed_count),
        .o_entries_held (o_entries_held),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Pending commands for the driver, and the words the table must still emit.
    op_t     cmd_q[$];
    result_t expected_words[$];

    // Shadow copy of the table, kept in insertion order.
    logic [KEY_W-1:0]   shadow_keys [DEPTH];
    logic [VALUE_W-1:0] shadow_vals [DEPTH];
    int                 shadow_fill = 0;

    logic [KEY_W-1:0] key_pool [5];

    int  gap_pct = 0;          // chance in a hundred that the sender idles a cycle
    bit  presenting = 1'b0;    // the front command sits on the ports
    bit  word_accepted = 1'b0; // start met a low busy at the last rising edge
    int  fail_count = 0;
    int  words_checked = 0;
    int  cycle_count = 0;
    int  n_add = 0, n_remove = 0, n_find = 0, n_unused = 0;
    int  n_full = 0, n_notfound = 0, n_removed = 0, most_hits = 0;

    // Append one word at the tail of the expectation queue.
    task automatic post_word(input result_t w);
        expected_words.insert(expected_words.size(), w);
    endtask

    // Work out the words one accepted command causes and update the shadow table.
    task automatic predict_words(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                 input logic [VALUE_W-1:0] val);
        result_t w;
        int      keep;
        int      hits;
        int      seen;
        w.status  = STATUS_OK;
        w.value   = '0;
        w.vld     = 1'b0;
        w.removed = '0;
        w.last    = 1'b1;
        case (cmd)
            CMD_ADD: begin
                if (shadow_fill >= DEPTH) begin
                    // Drop the pair and flag the table full.
                    w.status = STATUS_FULL;
                    n_full++;
                end else begin
                    shadow_keys[shadow_fill] = key;
                    shadow_vals[shadow_fill] = val;
                    shadow_fill++;
                end
                w.held = shadow_fill[CNT_OUT_W-1:0];
                post_word(w);
            end
            CMD_REMOVE: begin
                // Compact the survivors toward the front, keeping their order.
                keep = 0;
                for (int i = 0; i < shadow_fill; i++) begin
                    if (shadow_keys[i] != key) begin
                        shadow_keys[keep] = shadow_keys[i];
                        shadow_vals[keep] = shadow_vals[i];
                        keep++;
                    end
                end
                w.removed = CNT_OUT_W'(shadow_fill - keep);
                n_removed += shadow_fill - keep;
                shadow_fill = keep;
                w.held = shadow_fill[CNT_OUT_W-1:0];
                post_word(w);
            end
            CMD_FIND: begin
                w.held = shadow_fill[CNT_OUT_W-1:0];
                hits = 0;
                for (int i = 0; i < shadow_fill; i++)
                    if (shadow_keys[i] == key) hits++;
                if (hits == 0) begin
                    // One word, not found, nothing valid.
                    w.status = STATUS_NOTFOUND;
                    n_notfound++;
                    post_word(w);
                end else begin
                    // One word per match in stored order; mark only the final one.
                    if (hits > most_hits) most_hits = hits;
                    seen = 0;
                    for (int i = 0; i < shadow_fill; i++) begin
                        if (shadow_keys[i] == key) begin
                            seen++;
                            w.value = shadow_vals[i];
                            w.vld   = 1'b1;
                            w.last  = (seen == hits);
                            post_word(w);
                        end
                    end
                end
            end
            default: begin
                // Ignore the unused code; still answer with one word.
                w.held = shadow_fill[CNT_OUT_W-1:0];
                post_word(w);
            end
        endcase
    endtask

    task automatic queue_op(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] val);
        op_t op;
        op.cmd   = cmd;
        op.key   = key;
        op.value = val;
        cmd_q.insert(cmd_q.size(), op);
        case (cmd)
            CMD_ADD:    n_add++;
            CMD_REMOVE: n_remove++;
            CMD_FIND:   n_find++;
            default:    n_unused++;
        endcase
    endtask

    // Keys come mostly from a small pool so that duplicates and matches are common.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 88) return key_pool[$urandom_range(0, 4)];
        return $urandom;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '1;
        if (r < 10) return '0;
        return {$urandom, $urandom};
    endfunction

    // Mix runs of adds long enough to overflow the table with single commands.
    task automatic queue_random_ops(input int count);
        int made;
        int run;
        int r;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                run = $urandom_range(1, DEPTH + 2);
                repeat (run) queue_op(CMD_ADD, pick_key(), pick_value());
                made += run;
            end else begin
                if (r < 45)      queue_op(CMD_ADD, pick_key(), pick_value());
                else if (r < 72) queue_op(CMD_FIND, pick_key(), pick_value());
                else if (r < 93) queue_op(CMD_REMOVE, pick_key(), pick_value());
                else             queue_op(CMD_UNUSED, pick_key(), pick_value());
                made++;
            end
        end
    endtask

    // Hold off until every command is taken and every word has come out,
    // then let a full walk's worth of cycles pass to catch stray words.
    task automatic wait_drained();
        while (cmd_q.size() != 0 || expected_words.size() != 0 || busy)
            @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
    endtask

    // Driver: present the front command at the falling edge and keep start high
    // until the table takes it; idle between commands at the current gap rate.
    always @(negedge i_clk) begin : driver
        op_t nxt;
        if (presenting && word_accepted) begin
            void'(cmd_q.pop_front());
            presenting = 1'b0;
        end
        if (!presenting && cmd_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
            nxt = cmd_q[0];
            presenting = 1'b1;
            i_cmd   <= nxt.cmd;
            i_key   <= nxt.key;
            i_value <= nxt.value;
        end
        start <= presenting;
    end

    // Monitor: check the word under o_strobe against the oldest expectation,
    // then predict from any command taken at this edge.
    always @(posedge i_clk) begin : monitor
        result_t want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: status %0d value %h held %0d last %0b",
                                 o_status, o_found_value, o_entries_held, o_last);
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (o_status !== want.status || o_found_value !== want.value ||
                        o_value_valid !== want.vld || o_removed_count !== want.removed ||
                        o_entries_held !== want.held || o_last !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("word %0d mismatch (exp/got): status %0d/%0d value %h/%h",
                                     words_checked, want.status, o_status,
                                     want.value, o_found_value);
                            $display("  valid %0b/%0b removed %0d/%0d held %0d/%0d last %0b/%0b",
                                     want.vld, o_value_valid, want.removed, o_removed_count,
                                     want.held, o_entries_held, want.last, o_last);
                        end
                    end
                end
            end
            word_accepted = start && !busy;
            if (word_accepted) predict_words(i_cmd, i_key, i_value);
        end else begin
            word_accepted = 1'b0;
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = $urandom;
        key_pool[3] = $urandom;
        key_pool[4] = $urandom;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, extreme keys and values, duplicates,
        // no-match remove and find, and the unused code.
        gap_pct = 0;
        queue_op(CMD_FIND, 32'h0000_0007, '0);
        queue_op(CMD_REMOVE, 32'h0000_0007, '0);
        queue_op(CMD_UNUSED, '0, '0);
        queue_op(CMD_ADD, '0, '0);
        queue_op(CMD_ADD, '1, '1);
        queue_op(CMD_ADD, '0, 64'h0123_4567_89ab_cdef);
        queue_op(CMD_ADD, 32'h0000_0005, 64'ha5a5_5a5a_f00f_0ff0);
        queue_op(CMD_FIND, '0, '1);
        queue_op(CMD_FIND, '1, '0);
        queue_op(CMD_FIND, 32'h0000_0007, '0);
        queue_op(CMD_REMOVE, 32'h0000_0007, '1);
        queue_op(CMD_REMOVE, '0, '0);
        queue_op(CMD_FIND, '0, '0);
        queue_op(CMD_FIND, 32'h0000_0005, '0);
        queue_op(CMD_UNUSED, '1, '1);
        wait_drained();

        // Random: back to back, then a mostly idle sender, then light idling.
        gap_pct = 0;
        queue_random_ops(93);
        wait_drained();
        gap_pct = 75;
        queue_random_ops(93);
        wait_drained();
        gap_pct = 15;
        queue_random_ops(93);
        wait_drained();

        $display("commands: %0d add, %0d remove, %0d find, %0d unused; %0d words checked",
                 n_add, n_remove, n_find, n_unused, words_checked);
        $display("full drops %0d, finds without match %0d, pairs removed %0d, most hits %0d",
                 n_full, n_notfound, n_removed, most_hits);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: ordered_multimap_table.f
+incdir+rtl/core
rtl/core/otm_pkg.sv
rtl/core/otm_ram.sv
rtl/core/ordered_multimap_table.sv
tb/tb_ordered_multimap_table.sv
